// ===== sv/pic_pkg.sv =====
// shared types and constants of the priority interrupt controller
`timescale 1ns / 1ps
`default_nettype none

package pic_pkg;

    // lines are grouped in rows of this many lanes for storage and scanning
    localparam int LANES  = 16;
    localparam int LANE_W = 4;

    // operation codes on the input channel
    localparam logic [3:0] OP_ENABLE    = 4'd0;
    localparam logic [3:0] OP_DISABLE   = 4'd1;
    localparam logic [3:0] OP_SET_PRIO  = 4'd2;
    localparam logic [3:0] OP_GET_PRIO  = 4'd3;
    localparam logic [3:0] OP_SET_PEND  = 4'd4;
    localparam logic [3:0] OP_CLR_PEND  = 4'd5;
    localparam logic [3:0] OP_TEST_PEND = 4'd6;
    localparam logic [3:0] OP_READ_ERR  = 4'd7;
    localparam logic [3:0] OP_SERVICE   = 4'd8;

    // error codes
    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_LINE = 2'd1;
    localparam logic [1:0] ERR_PRIO = 2'd2;

    typedef enum logic [3:0] {
        K_ENABLE,
        K_DISABLE,
        K_SET_PRIO,
        K_GET_PRIO,
        K_SET_PEND,
        K_CLR_PEND,
        K_TEST_PEND,
        K_READ_ERR,
        K_SERVICE,
        K_NOP
    } t_kind;

    // classified command passed from front to back
    typedef struct packed {
        t_kind      kind;
        logic       line_ok;
        logic       prio_ok;
        logic [7:0] line;
        logic [7:0] prio;
    } t_cmd;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_EXEC
    } t_state;

endpackage

`default_nettype wire

// ===== sv/pic_front.sv =====
// front end: decodes the operation and checks line and priority ranges
`timescale 1ns / 1ps
`default_nettype none

module pic_front #(
    parameter int LINE_COUNT   = 240,
    parameter int PRIORITY_MAX = 15
) (
    input  wire logic [3:0]    i_operation,
    input  wire logic [7:0]    i_line,
    input  wire logic [7:0]    i_new_priority,
    output pic_pkg::t_cmd      o_cmd
);
    import pic_pkg::*;

    t_kind kind;

    always_comb begin
        unique case (i_operation)
            OP_ENABLE:    kind = K_ENABLE;
            OP_DISABLE:   kind = K_DISABLE;
            OP_SET_PRIO:  kind = K_SET_PRIO;
            OP_GET_PRIO:  kind = K_GET_PRIO;
            OP_SET_PEND:  kind = K_SET_PEND;
            OP_CLR_PEND:  kind = K_CLR_PEND;
            OP_TEST_PEND: kind = K_TEST_PEND;
            OP_READ_ERR:  kind = K_READ_ERR;
            OP_SERVICE:   kind = K_SERVICE;
            default:      kind = K_NOP;
        endcase
    end

    always_comb begin
        o_cmd.kind    = kind;
        o_cmd.line_ok = ({1'b0, i_line} < 9'(LINE_COUNT));
        o_cmd.prio_ok = ({1'b0, i_new_priority} <= 9'(PRIORITY_MAX));
        o_cmd.line    = i_line;
        o_cmd.prio    = i_new_priority;
    end

endmodule

`default_nettype wire

// ===== sv/pic_fifo.sv =====
// two-entry command queue between front and back
`timescale 1ns / 1ps
`default_nettype none

module pic_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire pic_pkg::t_cmd i_data,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_valid,
    output pic_pkg::t_cmd      o_data
);
    import pic_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !i_pop)
        else $error("pop from empty queue");
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_cnt == $past(r_cnt) + 2'd1))
        else $error("queue count did not follow push");
`endif

endmodule

`default_nettype wire

// ===== sv/pic_back.sv =====
// back end: line state, priority memory, row scan and result register
`timescale 1ns / 1ps
`default_nettype none

module pic_back #(
    parameter int LINE_COUNT   = 240,
    parameter int PRIORITY_MAX = 15
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_global_en,
    input  wire logic          i_cmd_valid,
    input  wire pic_pkg::t_cmd i_cmd,
    output logic               o_cmd_pop,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic               o_success,
    output logic [1:0]         o_error_code,
    output logic [3:0]         o_read_value,
    output logic               o_taken,
    output logic [7:0]         o_taken_line
);
    import pic_pkg::*;

    localparam int ROWS = (LINE_COUNT + LANES - 1) / LANES;
    localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int PW   = $clog2(PRIORITY_MAX + 1);
    localparam logic [PW-1:0] PMAX = PW'(PRIORITY_MAX);

    typedef logic [LANES-1:0][PW-1:0] t_row;

    typedef struct packed {
        logic              found;
        logic [PW-1:0]     prio;
        logic [LANE_W-1:0] lane;
    } t_cand;

    function automatic t_cand f_pick(input t_cand a, input t_cand b);
        t_cand c;
        c = a;
        if (b.found && (!a.found || (b.prio < a.prio))) begin
            c = b;
        end
        return c;
    endfunction

    function automatic logic [3:0] f_low4(input logic [PW-1:0] v);
        logic [PW+3:0] ext;
        ext = {4'b0000, v};
        return ext[3:0];
    endfunction

    // priority memory, one row of lanes per address
    t_row prio_mem [ROWS];
    t_row r_rd_row;

    // per-line flags; padding lanes past the last line never get set
    logic [ROWS-1:0][LANES-1:0] r_en;
    logic [ROWS-1:0][LANES-1:0] r_pend;
    logic [ROWS-1:0][LANES-1:0] r_pv;
    logic [1:0]                 r_err;
    logic [1:0]                 n_err;

    t_state r_state;
    t_state n_state;
    t_cmd   r_cmd;

    // scan pipeline
    logic [RW:0]   r_scan_cnt;
    logic          r_rd_vld;
    logic [RW-1:0] r_rd_idx;
    logic          r_rb_vld;
    logic [RW-1:0] r_rb_idx;
    t_cand         r_rb;
    logic          r_best_found;
    logic [PW-1:0] r_best_prio;
    logic [7:0]    r_best_line;

    logic          r_out_valid;

    logic [RW-1:0]     cmd_row;
    logic [LANE_W-1:0] cmd_lane;
    logic [RW-1:0]     best_row;
    logic [LANE_W-1:0] best_lane;
    logic              out_free;
    logic              scan_issue;
    logic              scan_done;
    logic              exec_fire;
    logic              rd_en;
    logic [RW-1:0]     rd_addr;

    logic              res_success;
    logic [3:0]        res_read;
    logic              res_taken;
    logic [7:0]        res_line;
    logic              en_we;
    logic              en_val;
    logic              pd_we;
    logic              pd_val;
    logic [RW-1:0]     pd_row;
    logic [LANE_W-1:0] pd_lane;
    logic              pr_we;
    logic [PW-1:0]     lane_prio;

    t_cand cand [LANE_W+1][LANES];

    assign cmd_row   = r_cmd.line[LANE_W +: RW];
    assign cmd_lane  = r_cmd.line[LANE_W-1:0];
    assign best_row  = r_best_line[LANE_W +: RW];
    assign best_lane = r_best_line[LANE_W-1:0];

    assign out_free   = !r_out_valid || i_ready;
    assign scan_issue = (r_state == S_SCAN) && (r_scan_cnt < (RW+1)'(ROWS));
    assign scan_done  = (r_state == S_SCAN) && !scan_issue && !r_rd_vld && !r_rb_vld;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    if ((i_cmd.kind == K_SERVICE) && i_global_en) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                n_state = S_EXEC;
            end
            S_SCAN: begin
                if (scan_done) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_cmd_pop = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = cmd_row;
        exec_fire = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd_pop = i_cmd_valid;
            end
            S_READ: begin
                rd_en = 1'b1;
            end
            S_SCAN: begin
                rd_en   = scan_issue;
                rd_addr = r_scan_cnt[RW-1:0];
            end
            S_EXEC: begin
                exec_fire = out_free;
            end
            default: begin
                o_cmd_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
        end
    end

    // memory: one write lane, one registered row read
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_row <= prio_mem[rd_addr];
        end
        if (exec_fire && pr_we) begin
            prio_mem[cmd_row][cmd_lane] <= r_cmd.prio[PW-1:0];
        end
    end

    // row reduction tree, lower lane wins ties
    always_comb begin
        for (int l = 0; l <= LANE_W; l++) begin
            for (int j = 0; j < LANES; j++) begin
                cand[l][j] = '0;
            end
        end
        for (int j = 0; j < LANES; j++) begin
            cand[0][j].found = r_en[r_rd_idx][j] & r_pend[r_rd_idx][j];
            cand[0][j].prio  = r_pv[r_rd_idx][j] ? r_rd_row[j] : PMAX;
            cand[0][j].lane  = LANE_W'(j);
        end
        for (int l = 0; l < LANE_W; l++) begin
            for (int j = 0; j < (LANES >> (l + 1)); j++) begin
                cand[l+1][j] = f_pick(cand[l][2*j], cand[l][2*j+1]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_cnt   <= '0;
            r_rd_vld     <= 1'b0;
            r_rb_vld     <= 1'b0;
            r_best_found <= 1'b0;
        end else if (o_cmd_pop) begin
            r_scan_cnt   <= '0;
            r_rd_vld     <= 1'b0;
            r_rb_vld     <= 1'b0;
            r_best_found <= 1'b0;
        end else begin
            r_rd_vld <= scan_issue;
            r_rb_vld <= r_rd_vld;
            if (scan_issue) begin
                r_scan_cnt <= r_scan_cnt + (RW+1)'(1);
            end
            // rows arrive in increasing order, so strict less keeps lowest line
            if (r_rb_vld && r_rb.found && (!r_best_found || (r_rb.prio < r_best_prio))) begin
                r_best_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (scan_issue) begin
            r_rd_idx <= r_scan_cnt[RW-1:0];
        end
        if (r_rd_vld) begin
            r_rb     <= cand[LANE_W][0];
            r_rb_idx <= r_rd_idx;
        end
        if (r_rb_vld && r_rb.found && (!r_best_found || (r_rb.prio < r_best_prio))) begin
            r_best_prio <= r_rb.prio;
            r_best_line <= {4'(r_rb_idx), r_rb.lane};
        end
    end

    // execute
    always_comb begin
        n_err       = r_err;
        res_success = 1'b0;
        res_read    = 4'd0;
        res_taken   = 1'b0;
        res_line    = 8'd0;
        en_we       = 1'b0;
        en_val      = 1'b0;
        pd_we       = 1'b0;
        pd_val      = 1'b0;
        pd_row      = cmd_row;
        pd_lane     = cmd_lane;
        pr_we       = 1'b0;
        lane_prio   = r_pv[cmd_row][cmd_lane] ? r_rd_row[cmd_lane] : PMAX;
        case (r_cmd.kind)
            K_ENABLE, K_DISABLE, K_SET_PEND, K_CLR_PEND: begin
                if (!r_cmd.line_ok) begin
                    n_err = ERR_LINE;
                end else begin
                    n_err       = ERR_NONE;
                    res_success = 1'b1;
                    en_we       = (r_cmd.kind == K_ENABLE) || (r_cmd.kind == K_DISABLE);
                    en_val      = (r_cmd.kind == K_ENABLE);
                    pd_we       = (r_cmd.kind == K_SET_PEND) || (r_cmd.kind == K_CLR_PEND);
                    pd_val      = (r_cmd.kind == K_SET_PEND);
                end
            end
            K_SET_PRIO: begin
                if (!r_cmd.line_ok) begin
                    n_err = ERR_LINE;
                end else if (!r_cmd.prio_ok) begin
                    n_err = ERR_PRIO;
                end else begin
                    n_err       = ERR_NONE;
                    res_success = 1'b1;
                    pr_we       = 1'b1;
                end
            end
            K_GET_PRIO: begin
                res_read = r_cmd.line_ok ? f_low4(lane_prio) : f_low4(PMAX);
            end
            K_TEST_PEND: begin
                res_read = r_cmd.line_ok ? {3'b000, r_pend[cmd_row][cmd_lane]} : 4'd0;
            end
            K_SERVICE: begin
                if (r_best_found) begin
                    res_taken = 1'b1;
                    res_line  = r_best_line;
                    pd_we     = 1'b1;
                    pd_val    = 1'b0;
                    pd_row    = best_row;
                    pd_lane   = best_lane;
                end
            end
            default: begin
                n_err = r_err;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en  <= '0;
            r_pend <= '0;
            r_pv  <= '0;
            r_err <= ERR_NONE;
        end else if (exec_fire) begin
            r_err <= n_err;
            if (en_we) begin
                r_en[cmd_row][cmd_lane] <= en_val;
            end
            if (pd_we) begin
                r_pend[pd_row][pd_lane] <= pd_val;
            end
            if (pr_we) begin
                r_pv[cmd_row][cmd_lane] <= 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exec_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec_fire) begin
            o_success    <= res_success;
            o_error_code <= n_err;
            o_read_value <= res_read;
            o_taken      <= res_taken;
            o_taken_line <= res_line;
        end
    end

    assign o_valid = r_out_valid;

`ifndef SYNTH
    a_taken_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && o_taken) |-> ({1'b0, o_taken_line} < 9'(LINE_COUNT)))
        else $error("serviced line out of range");
    a_exec_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && r_out_valid && !i_ready) |=> (r_state == S_EXEC))
        else $error("result overwritten while stalled");
    a_best_eligible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && r_cmd.kind == K_SERVICE && r_best_found)
            |-> (r_en[best_row][best_lane] && r_pend[best_row][best_lane]))
        else $error("selected line not enabled and pending");
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_scan_cnt <= (RW+1)'(ROWS)))
        else $error("scan counter past last row");
`endif

endmodule

`default_nettype wire

// ===== sv/priority_interrupt_controller_unit.sv =====
// top level of the priority interrupt controller
// a register operation passes from the queue through the idle, read and execute states
// into the result register; an enabled service goes through the scan state instead of read
// the back end executes one command at a time; the queue takes new beats while it has room
// the service time grows with the scan, which reads one 16-line row of priority memory a cycle
// reset: all lines disabled and not pending, priorities at the maximum, error cleared,
// global enable set; no clearing pass, the block takes beats as soon as reset is released
`timescale 1ns / 1ps
`default_nettype none

module priority_interrupt_controller_unit #(
    parameter int LINE_COUNT   = 240,
    parameter int PRIORITY_MAX = 15
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // operation channel
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [3:0] i_operation,
    input  wire logic [7:0] i_line,
    input  wire logic [7:0] i_new_priority,
    // result channel
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic            o_success,
    output logic [1:0]      o_error_code,
    output logic [3:0]      o_read_value,
    output logic            o_taken,
    output logic [7:0]      o_taken_line,
    // configuration write channel
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic       i_cfg_global_enable
);
    import pic_pkg::*;

    t_cmd front_cmd;
    t_cmd queue_cmd;
    logic queue_full;
    logic queue_valid;
    logic queue_pop;
    logic push;

    // global enable register, always writable
    logic r_global_en;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_global_en <= 1'b1;
        end else if (i_cfg_valid) begin
            r_global_en <= i_cfg_global_enable;
        end
    end

    // front: classify each beat as it arrives
    pic_front #(
        .LINE_COUNT   (LINE_COUNT),
        .PRIORITY_MAX (PRIORITY_MAX)
    ) u_front (
        .i_operation    (i_operation),
        .i_line         (i_line),
        .i_new_priority (i_new_priority),
        .o_cmd          (front_cmd)
    );

    // input side keeps taking beats as long as the queue has room,
    // independent of what the back end is doing
    assign o_ready = !queue_full;
    assign push    = i_valid && !queue_full;

    pic_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cmd),
        .o_full  (queue_full),
        .i_pop   (queue_pop),
        .o_valid (queue_valid),
        .o_data  (queue_cmd)
    );

    // back: executes one command at a time, owns all line state,
    // and holds its result in an output register until taken
    pic_back #(
        .LINE_COUNT   (LINE_COUNT),
        .PRIORITY_MAX (PRIORITY_MAX)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_global_en  (r_global_en),
        .i_cmd_valid  (queue_valid),
        .i_cmd        (queue_cmd),
        .o_cmd_pop    (queue_pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_success    (o_success),
        .o_error_code (o_error_code),
        .o_read_value (o_read_value),
        .o_taken      (o_taken),
        .o_taken_line (o_taken_line)
    );

endmodule

`default_nettype wire

// ===== sim/priority_interrupt_controller_unit_tb.sv =====
// testbench of the priority interrupt controller: random and directed operations, scoreboard
`timescale 1ns / 1ps

module priority_interrupt_controller_unit_tb;
    import pic_pkg::*;

    localparam int TB_LINES    = 240;
    localparam int TB_PRIO_MAX = 15;

    typedef struct packed {
        logic       success;
        logic [1:0] error_code;
        logic [3:0] read_value;
        logic       taken;
        logic [7:0] taken_line;
    } t_irq_result;

    // mirror of the controller state plus the queue of results still owed by the block
    class t_irq_tracker;
        bit          line_en   [TB_LINES];
        bit          line_pend [TB_LINES];
        logic [3:0]  line_prio [TB_LINES];
        logic [1:0]  last_err;
        bit          global_en;
        t_irq_result owed_results[$];
        int          mismatches;
        int          ops_seen;
        int          results_seen;
        int          services_taken;
        int          services_empty;
        int          error_results;

        function new();
            for (int i = 0; i < TB_LINES; i++) begin
                line_en[i]   = 1'b0;
                line_pend[i] = 1'b0;
                line_prio[i] = TB_PRIO_MAX[3:0];
            end
            last_err  = ERR_NONE;
            global_en = 1'b1;
        endfunction

        function void set_global(bit v);
            global_en = v;
        endfunction

        function int outstanding();
            return owed_results.size();
        endfunction

        // apply one accepted operation to the mirror and queue what the block must answer
        function void note_op(logic [3:0] op, logic [7:0] line, logic [7:0] new_prio);
            t_irq_result r;
            bit          ok;
            bit          found;
            int          best;
            r     = '0;
            ok    = (int'(line) < TB_LINES);
            found = 1'b0;
            best  = 0;
            ops_seen++;
            case (op)
                OP_ENABLE, OP_DISABLE, OP_SET_PEND, OP_CLR_PEND: begin
                    if (!ok) begin
                        last_err = ERR_LINE;
                    end else begin
                        if (op == OP_ENABLE) line_en[line] = 1'b1;
                        else if (op == OP_DISABLE) line_en[line] = 1'b0;
                        else if (op == OP_SET_PEND) line_pend[line] = 1'b1;
                        else line_pend[line] = 1'b0;
                        last_err  = ERR_NONE;
                        r.success = 1'b1;
                    end
                end
                OP_SET_PRIO: begin
                    // an invalid line outranks an out of range priority
                    if (!ok) begin
                        last_err = ERR_LINE;
                    end else if (int'(new_prio) > TB_PRIO_MAX) begin
                        last_err = ERR_PRIO;
                    end else begin
                        line_prio[line] = new_prio[3:0];
                        last_err  = ERR_NONE;
                        r.success = 1'b1;
                    end
                end
                OP_GET_PRIO:  r.read_value = ok ? line_prio[line] : TB_PRIO_MAX[3:0];
                OP_TEST_PEND: r.read_value = ok ? {3'b000, line_pend[line]} : 4'd0;
                OP_SERVICE: begin
                    if (global_en) begin
                        for (int i = 0; i < TB_LINES; i++) begin
                            if (line_en[i] && line_pend[i] &&
                                (!found || line_prio[i] < line_prio[best])) begin
                                best  = i;
                                found = 1'b1;
                            end
                        end
                    end
                    if (found) begin
                        line_pend[best] = 1'b0;
                        r.taken         = 1'b1;
                        r.taken_line    = best[7:0];
                        services_taken++;
                    end else begin
                        services_empty++;
                    end
                end
                default: ;
            endcase
            r.error_code = last_err;
            owed_results.push_back(r);
        endfunction

        function void check_result(logic success, logic [1:0] err, logic [3:0] rd,
                                   logic taken, logic [7:0] tline);
            t_irq_result got;
            t_irq_result want;
            string       exp_s;
            string       got_s;
            got = {success, err, rd, taken, tline};
            results_seen++;
            if (err != ERR_NONE) error_results++;
            got_s = $sformatf("success %0d err %0d read %0d taken %0d line %0d",
                              success, err, rd, taken, tline);
            if (owed_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: %s", got_s);
                return;
            end
            want = owed_results.pop_front();
            if (got !== want) begin
                mismatches++;
                exp_s = $sformatf("success %0d err %0d read %0d taken %0d line %0d",
                                  want.success, want.error_code, want.read_value,
                                  want.taken, want.taken_line);
                if (mismatches <= 10)
                    $display("mismatch on result %0d: expected %s, got %s",
                             results_seen, exp_s, got_s);
            end
        endfunction
    endclass

    // cycles with no beat on any channel before the run is declared hung
    localparam int STALL_LIMIT = 5000;
    // quiet cycles after the last result, longer than a full service
    localparam int SETTLE      = 40;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 143;

    logic       i_clk;
    logic       i_rst_n             = 1'b0;
    logic       i_valid             = 1'b0;
    logic [3:0] i_operation         = 4'd0;
    logic [7:0] i_line              = 8'd0;
    logic [7:0] i_new_priority      = 8'd0;
    logic       i_ready             = 1'b0;
    logic       i_cfg_valid         = 1'b0;
    logic       i_cfg_global_enable = 1'b1;
    logic       o_ready;
    logic       o_valid;
    logic       o_success;
    logic [1:0] o_error_code;
    logic [3:0] o_read_value;
    logic       o_taken;
    logic [7:0] o_taken_line;
    logic       o_cfg_ready;

    t_irq_tracker tracker = new();

    // stall and gap percentages of the current phase
    int stall_pct     = 0;
    int send_idle_pct = 0;
    int idle_cycles   = 0;
    int cfg_writes    = 0;
    int phases_run    = 0;

    // lines that random traffic keeps coming back to, so that services find work and ties
    logic [7:0] hot_lines [8] = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd100, 8'd237, 8'd238, 8'd239};

    priority_interrupt_controller_unit #(
        .LINE_COUNT   (TB_LINES),
        .PRIORITY_MAX (TB_PRIO_MAX)
    ) dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_operation         (i_operation),
        .i_line              (i_line),
        .i_new_priority      (i_new_priority),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_success           (o_success),
        .o_error_code        (o_error_code),
        .o_read_value        (o_read_value),
        .o_taken             (o_taken),
        .o_taken_line        (o_taken_line),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_global_enable (i_cfg_global_enable)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // result side backpressure, redrawn every cycle
    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // both monitors sample at the edge, so they see the values the block saw
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready)
                tracker.check_result(o_success, o_error_code, o_read_value, o_taken,
                                     o_taken_line);
            if (i_valid && o_ready)
                tracker.note_op(i_operation, i_line, i_new_priority);
        end
    end

    // watchdog: any beat on any channel restarts the count
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("watchdog: no beat for %0d cycles, %0d results still owed",
                         STALL_LIMIT, tracker.outstanding());
                $display("priority_interrupt_controller_unit_tb: FAIL");
                $finish;
            end
        end
    end

    // one operation beat; returns at the edge that accepted it with valid still high
    task automatic send_op(input logic [3:0] op, input logic [7:0] line,
                           input logic [7:0] new_prio);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_operation    <= op;
        i_line         <= line;
        i_new_priority <= new_prio;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // let every owed result come back, then give the block time to go quiet
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (tracker.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_global_enable(input bit v);
        i_cfg_valid         <= 1'b1;
        i_cfg_global_enable <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        tracker.set_global(v);
        cfg_writes++;
    endtask

    initial begin
        int         r;
        int         fails;
        logic [3:0] op;
        logic [7:0] ln;
        logic [7:0] np;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part, no idling
        write_global_enable(1'b1);
        send_op(OP_ENABLE,    8'd0,   8'd0);
        send_op(OP_ENABLE,    8'd239, 8'd0);
        send_op(OP_ENABLE,    8'd240, 8'd0);     // first invalid line
        send_op(OP_SET_PRIO,  8'd0,   8'd0);
        send_op(OP_SET_PRIO,  8'd239, 8'd15);
        send_op(OP_SET_PRIO,  8'd10,  8'd16);    // priority just past the maximum
        send_op(OP_SET_PRIO,  8'd255, 8'd255);   // both faults, line error wins
        send_op(OP_GET_PRIO,  8'd0,   8'd0);
        send_op(OP_GET_PRIO,  8'd255, 8'd0);     // invalid line reads the maximum
        send_op(OP_SET_PEND,  8'd0,   8'd0);
        send_op(OP_SET_PEND,  8'd239, 8'd0);
        send_op(OP_TEST_PEND, 8'd239, 8'd0);
        send_op(OP_TEST_PEND, 8'd250, 8'd0);     // invalid line reads zero
        send_op(OP_READ_ERR,  8'd0,   8'd0);
        send_op(OP_SERVICE,   8'd0,   8'd0);     // most urgent line 0
        send_op(OP_SERVICE,   8'd0,   8'd0);     // then line 239
        send_op(OP_SERVICE,   8'd0,   8'd0);     // nothing left
        send_op(OP_CLR_PEND,  8'd255, 8'd0);
        send_op(OP_ENABLE,    8'd3,   8'd0);
        send_op(OP_ENABLE,    8'd5,   8'd0);
        send_op(OP_SET_PEND,  8'd5,   8'd0);
        send_op(OP_SET_PEND,  8'd3,   8'd0);
        send_op(OP_SERVICE,   8'd0,   8'd0);     // equal priorities, lower index wins
        send_op(OP_DISABLE,   8'd5,   8'd0);
        send_op(4'd9,         8'd17,  8'd3);     // unused codes
        send_op(4'd15,        8'd255, 8'd255);

        // random part: idling mode rotates, global enable off in some phases
        for (int ph = 0; ph < PHASES; ph++) begin
            wait_idle();
            write_global_enable(ph % 3 != 2);
            case (ph % 4)
                0: begin stall_pct <= 0;  send_idle_pct = 0;  end
                1: begin stall_pct <= 0;  send_idle_pct = 57; end
                2: begin stall_pct <= 57; send_idle_pct = 0;  end
                default: begin stall_pct <= 6; send_idle_pct = 6; end
            endcase
            phases_run++;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                r = $urandom_range(0, 99);
                if (r < 14) op = OP_ENABLE;
                else if (r < 18) op = OP_DISABLE;
                else if (r < 30) op = OP_SET_PRIO;
                else if (r < 37) op = OP_GET_PRIO;
                else if (r < 55) op = OP_SET_PEND;
                else if (r < 60) op = OP_CLR_PEND;
                else if (r < 66) op = OP_TEST_PEND;
                else if (r < 70) op = OP_READ_ERR;
                else if (r < 96) op = OP_SERVICE;
                else op = 4'($urandom_range(9, 15));

                r = $urandom_range(0, 99);
                if (r < 65) ln = hot_lines[$urandom_range(0, 7)];
                else if (r < 90) ln = 8'($urandom_range(0, TB_LINES - 1));
                else ln = 8'($urandom_range(0, 255));

                // few distinct priorities make ties common
                r = $urandom_range(0, 99);
                if (r < 45) np = 8'($urandom_range(0, 3));
                else if (r < 85) np = 8'($urandom_range(0, TB_PRIO_MAX));
                else np = 8'($urandom_range(0, 255));

                send_op(op, ln, np);
            end
        end

        wait_idle();
        stall_pct <= 0;

        fails = tracker.mismatches + tracker.outstanding();
        $display("ran %0d operations in %0d random phases plus a directed part, %0d enable writes",
                 tracker.ops_seen, phases_run, cfg_writes);
        $display("%0d results checked: %0d services took a line, %0d found none, %0d with error",
                 tracker.results_seen, tracker.services_taken, tracker.services_empty,
                 tracker.error_results);
        if (fails == 0) begin
            $display("priority_interrupt_controller_unit_tb: PASS");
        end else begin
            $display("%0d mismatches, %0d results never arrived",
                     tracker.mismatches, tracker.outstanding());
            $display("priority_interrupt_controller_unit_tb: FAIL");
        end
        $finish;
    end

endmodule
